// File: src/pf_pkg.sv
`default_nettype none

package pf_pkg;

    // Field widths
    localparam int TICK_W = 16;
    localparam int LEN_W  = 16;
    localparam int BYTE_W = 8;
    localparam int CAP_W  = 10;
    localparam int SEQ_W  = 8;
    localparam int FCNT_W = 9;

    // Message limits
    localparam int MAX_PAYLOAD = 65535;
    localparam int MAX_FRAMES  = 256;

    // Slice capacity bounds and reset value
    localparam int CAP_MIN   = 1;
    localparam int CAP_MAX   = 512;
    localparam int CAP_RESET = 16;

    // Divider: dividend is len + cap - 1, one quotient bit per step
    localparam int DIVIDEND_W = LEN_W + 1;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

    // Output slot codes within one request
    localparam int SLOT_W = 3;
    localparam logic [SLOT_W-1:0] SLOT_TICK_LO = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_TICK_HI = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_SEQ     = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_LAST    = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_DATA    = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } pf_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pf_div_stat_t;

endpackage

`default_nettype wire

// File: src/pf_if.sv
`default_nettype none

// Message channel: one request per payload byte
interface pf_msg_if;
    import pf_pkg::*;

    logic              valid;
    logic              ready;
    logic              first;
    logic [TICK_W-1:0] tick_id;
    logic [LEN_W-1:0]  payload_len;
    logic              has_data;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, first, tick_id, payload_len, has_data, data_byte,
                    input ready);
    modport sink   (input valid, first, tick_id, payload_len, has_data, data_byte,
                    output ready);
endinterface

// Frame channel: one request per header or payload byte
interface pf_frm_if;
    import pf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;
    logic              message_end;

    modport source (output valid, out_byte, frame_end, message_end, input ready);
    modport sink   (input valid, out_byte, frame_end, message_end, output ready);
endinterface

`default_nettype wire

// File: src/payload_fragmenter.sv
// Payload fragmenter
// msg (sink): one request per payload byte. A request with first=1 carries
//   tick_id and payload_len; has_data=0 marks the single request of an empty
//   message. frm (source): one request per header or payload byte, with
//   frame_end on the last byte of a frame and message_end on the last byte
//   of the message. Each frame opens with tick low, tick high, sequence
//   number and last sequence number.
// cfg_we/cfg_wdata write slice_cap (payload bytes per frame, 0 taken as 1,
//   above 512 taken as 512); write only while the block is idle.
// Flow: a plain payload byte is accepted, then loaded into the output
//   register; one that opens a frame is preceded by its header bytes.
//   A first request also sets the frame count through the restoring
//   divider, which retires one quotient bit per cycle.
// The output register holds a result while frm.ready is low; the next
//   request is taken meanwhile, but no further result is loaded until the
//   held one is taken, and msg.ready stays low while a request is emitting.
// Reset clears all control state, the frame counters and the output valid;
//   slice_cap returns to 16.
`default_nettype none

module payload_fragmenter
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [pf_pkg::CAP_W-1:0] cfg_wdata,
    pf_msg_if.sink                        msg,
    pf_frm_if.source                      frm
);
    import pf_pkg::*;

    logic [CAP_W-1:0]      slice_cap_reg;
    logic [CAP_W-1:0]      cap_eff;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVIDEND_W-1:0] div_quotient;
    pf_div_stat_t          div_stat;

    // Hold the slice capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slice_cap_reg <= CAP_W'(CAP_RESET);
        else if (cfg_we)
            slice_cap_reg <= cfg_wdata;
    end

    // Clamp the capacity into its working range
    always_comb
    begin
        if (slice_cap_reg < CAP_W'(CAP_MIN))
            cap_eff = CAP_W'(CAP_MIN);
        else if (slice_cap_reg > CAP_W'(CAP_MAX))
            cap_eff = CAP_W'(CAP_MAX);
        else
            cap_eff = slice_cap_reg;
    end

    pf_framer u_framer
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cap          (cap_eff),
        .msg          (msg),
        .frm          (frm),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_stat     (div_stat),
        .div_quotient (div_quotient)
    );

    pf_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cap_eff),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

endmodule

`default_nettype wire

// File: src/pf_divider.sv
`default_nettype none

module pf_divider
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [pf_pkg::DIVIDEND_W-1:0]  dividend,
    input  wire logic [pf_pkg::CAP_W-1:0]       divisor,
    output pf_pkg::pf_div_stat_t                stat,
    output logic      [pf_pkg::DIVIDEND_W-1:0]  quotient
);
    import pf_pkg::*;

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [CAP_W-1:0]      rem_reg, rem_next;
    logic [CAP_W-1:0]      dsr_reg, dsr_next;
    logic [DCNT_W-1:0]     cnt_reg, cnt_next;
    logic                  done_reg, done_next;

    logic [CAP_W:0]        rem_sh;
    logic [CAP_W:0]        rem_sub;
    logic                  ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_sub = rem_sh - {1'b0, dsr_reg};
        ge      = (rem_sh >= {1'b0, dsr_reg});

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = DCNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            quo_next  = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next  = ge ? rem_sub[CAP_W-1:0] : rem_sh[CAP_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DCNT_W'(1));
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// File: src/pf_framer.sv
`default_nettype none

module pf_framer
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [pf_pkg::CAP_W-1:0]      cap,
    pf_msg_if.sink                             msg,
    pf_frm_if.source                           frm,
    output logic                               div_start,
    output logic      [pf_pkg::DIVIDEND_W-1:0] div_dividend,
    input  wire pf_pkg::pf_div_stat_t          div_stat,
    input  wire logic [pf_pkg::DIVIDEND_W-1:0] div_quotient
);
    import pf_pkg::*;

    localparam logic [DIVIDEND_W-1:0] FRAMES_Q   = DIVIDEND_W'(MAX_FRAMES);
    localparam logic [SEQ_W-1:0]      LAST_MAX   = SEQ_W'(MAX_FRAMES - 1);
    localparam logic [FCNT_W-1:0]     FRAMES_F   = FCNT_W'(MAX_FRAMES);
    localparam logic [LEN_W:0]        PAYLOAD_MX = (MAX_PAYLOAD > 65535) ?
                                                   17'h0FFFF : (LEN_W+1)'(MAX_PAYLOAD);

    pf_state_t             state_reg, state_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [SEQ_W-1:0]      last_seq_reg, last_seq_next;
    logic [FCNT_W-1:0]     fcnt_reg, fcnt_next;
    logic [CAP_W-1:0]      spos_reg, spos_next;
    logic [LEN_W-1:0]      left_reg, left_next;
    logic [BYTE_W-1:0]     dbyte_reg, dbyte_next;
    logic                  has_reg, has_next;
    logic                  empty_reg, empty_next;
    logic                  alone_reg, alone_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0]     obyte_reg, obyte_next;
    logic                  ofe_reg, ofe_next;
    logic                  ome_reg, ome_next;

    logic [LEN_W-1:0]      len_sat;
    logic                  decide;
    logic                  d_has;
    logic                  d_empty;
    logic                  slot_free;
    logic [CAP_W-1:0]      spos_inc;
    logic [LEN_W-1:0]      left_dec;
    logic                  fend;
    logic                  mend;

    assign msg.ready = (state_reg == ST_IDLE);
    assign slot_free = !ovalid_reg || frm.ready;

    // Saturate the message length
    always_comb
    begin
        if ({1'b0, msg.payload_len} > PAYLOAD_MX)
            len_sat = PAYLOAD_MX[LEN_W-1:0];
        else
            len_sat = msg.payload_len;
    end

    assign div_dividend = {1'b0, len_sat} + DIVIDEND_W'(cap) - DIVIDEND_W'(1);

    // Data byte framing
    assign spos_inc = spos_reg + 1'b1;
    assign left_dec = left_reg - 1'b1;
    assign fend     = (spos_inc >= cap) || (left_dec == '0);
    assign mend     = fend && (fcnt_reg == {1'b0, last_seq_reg});

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        tick_next     = tick_reg;
        last_seq_next = last_seq_reg;
        fcnt_next     = fcnt_reg;
        spos_next     = spos_reg;
        left_next     = left_reg;
        dbyte_next    = dbyte_reg;
        has_next      = has_reg;
        empty_next    = empty_reg;
        alone_next    = alone_reg;
        slot_next     = slot_reg;
        ovalid_next   = ovalid_reg;
        obyte_next    = obyte_reg;
        ofe_next      = ofe_reg;
        ome_next      = ome_reg;
        div_start     = 1'b0;
        decide        = 1'b0;
        d_has         = has_reg;
        d_empty       = empty_reg;

        // Drop the output slot once taken
        if (ovalid_reg && frm.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    dbyte_next = msg.data_byte;
                    if (msg.first)
                    begin
                        tick_next  = msg.tick_id;
                        left_next  = len_sat;
                        fcnt_next  = '0;
                        spos_next  = '0;
                        has_next   = msg.has_data;
                        empty_next = (len_sat == '0);
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                    else
                    begin
                        decide  = 1'b1;
                        d_has   = msg.has_data;
                        d_empty = 1'b0;
                    end
                end
            end

            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    if (div_quotient == '0)
                        last_seq_next = '0;
                    else if (div_quotient >= FRAMES_Q)
                        last_seq_next = LAST_MAX;
                    else
                        last_seq_next = SEQ_W'(div_quotient - 1'b1);
                    decide = 1'b1;
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    ofe_next    = 1'b0;
                    ome_next    = 1'b0;
                    slot_next   = slot_reg + 1'b1;
                    case (slot_reg)
                        SLOT_TICK_LO: obyte_next = tick_reg[7:0];
                        SLOT_TICK_HI: obyte_next = tick_reg[15:8];
                        SLOT_SEQ:     obyte_next = fcnt_reg[SEQ_W-1:0];
                        SLOT_LAST:
                        begin
                            obyte_next = last_seq_reg;
                            if (alone_reg)
                            begin
                                ofe_next   = 1'b1;
                                ome_next   = 1'b1;
                                fcnt_next  = FCNT_W'(1);
                                state_next = ST_IDLE;
                            end
                        end
                        SLOT_DATA:
                        begin
                            obyte_next = dbyte_reg;
                            ofe_next   = fend;
                            ome_next   = mend;
                            left_next  = left_dec;
                            if (fend)
                            begin
                                spos_next = '0;
                                fcnt_next = fcnt_reg + 1'b1;
                            end
                            else
                            begin
                                spos_next = spos_inc;
                            end
                            state_next = ST_IDLE;
                        end
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end

            default: state_next = ST_IDLE;
        endcase

        // Route the request: header-only frame, skip, drop or emit
        if (decide)
        begin
            if (d_empty)
            begin
                alone_next = 1'b1;
                slot_next  = SLOT_TICK_LO;
                state_next = ST_EMIT;
            end
            else if (!d_has || (left_reg == '0))
            begin
                state_next = ST_IDLE;
            end
            else if (fcnt_reg >= FRAMES_F)
            begin
                left_next  = left_dec;
                state_next = ST_IDLE;
            end
            else
            begin
                alone_next = 1'b0;
                slot_next  = (spos_reg == '0) ? SLOT_TICK_LO : SLOT_DATA;
                state_next = ST_EMIT;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tick_reg     <= '0;
            last_seq_reg <= '0;
            fcnt_reg     <= '0;
            spos_reg     <= '0;
            left_reg     <= '0;
            ovalid_reg   <= 1'b0;
            slot_reg     <= '0;
            alone_reg    <= 1'b0;
            has_reg      <= 1'b0;
            empty_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            last_seq_reg <= last_seq_next;
            fcnt_reg     <= fcnt_next;
            spos_reg     <= spos_next;
            left_reg     <= left_next;
            ovalid_reg   <= ovalid_next;
            slot_reg     <= slot_next;
            alone_reg    <= alone_next;
            has_reg      <= has_next;
            empty_reg    <= empty_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        dbyte_reg <= dbyte_next;
        obyte_reg <= obyte_next;
        ofe_reg   <= ofe_next;
        ome_reg   <= ome_next;
    end

    assign frm.valid       = ovalid_reg;
    assign frm.out_byte    = obyte_reg;
    assign frm.frame_end   = ofe_reg;
    assign frm.message_end = ome_reg;

endmodule

`default_nettype wire

// File: src/pf_checker.sv
`default_nettype none

module pf_checker
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      msg_valid,
    input  wire logic                      msg_ready,
    input  wire logic                      msg_first,
    input  wire logic                      msg_has_data,
    input  wire logic                      frm_valid,
    input  wire logic                      frm_ready,
    input  wire logic [pf_pkg::BYTE_W-1:0] frm_out_byte,
    input  wire logic                      frm_frame_end,
    input  wire logic                      frm_message_end
);
    import pf_pkg::*;

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid && !frm_ready |=> frm_valid && $stable(frm_out_byte)
            && $stable(frm_frame_end) && $stable(frm_message_end))
        else $error("stalled frame byte changed");

    // Message end only closes a frame
    a_mend_fend: assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid && frm_message_end |-> frm_frame_end)
        else $error("message_end without frame_end");

    // A message start always runs the frame count, so the port closes
    a_first_busy: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && msg_first |=> !msg_ready)
        else $error("ready held after message start");

    // A request without data inside a message emits nothing and keeps ready
    a_nodata_idle: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && !msg_first && !msg_has_data |=> msg_ready)
        else $error("ready dropped after request without data");

endmodule

bind payload_fragmenter pf_checker u_pf_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .msg_valid       (msg.valid),
    .msg_ready       (msg.ready),
    .msg_first       (msg.first),
    .msg_has_data    (msg.has_data),
    .frm_valid       (frm.valid),
    .frm_ready       (frm.ready),
    .frm_out_byte    (frm.out_byte),
    .frm_frame_end   (frm.frame_end),
    .frm_message_end (frm.message_end)
);

`default_nettype wire
